// ===== src/chm_pkg.sv =====
// Shared types and codes for the coalesced chaining hash map.
// No dependencies; imported by coalesced_hash_map and the testbench.
package chm_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_OTHER  = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HOME,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_DECIDE,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_LINK_TAIL,
    ST_REM_RD,
    ST_REM_CHK,
    ST_SPLICE,
    ST_UNLINK,
    ST_RESP
  } state_e;

endpackage

// ===== src/chm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/chm_mod.sv =====
// Radix-16 remainder unit: magnitude modulo CAPACITY, one nibble per cycle by
// compare and subtract against constant multiples. No dependencies.
module chm_mod #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [KEY_BITS-1:0]         mag_i,
  output logic                        done_o,
  output logic [$clog2(CAPACITY)-1:0] rem_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int NIB = (KEY_BITS + 3) / 4;
  localparam int PW = NIB * 4;
  localparam int CNTW = $clog2(NIB + 1);
  localparam int XW = IW + 4;

  logic [PW-1:0]   sh_q;
  logic [IW-1:0]   rem_q, rem_d;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q;
  logic [XW-1:0]   trial, sub;

  always_comb begin
    trial = {rem_q, sh_q[PW-1 -: 4]};
    sub   = '0;
    for (int k = 1; k < 16; k++) begin
      if (trial >= XW'(k * CAPACITY)) begin
        sub = XW'(k * CAPACITY);
      end
    end
    rem_d = IW'(trial - sub);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(NIB);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= PW'(mag_i);
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= sh_q << 4;
      rem_q <= rem_d;
    end
  end

  assign done_o = busy_q && (cnt_q == CNTW'(1));
  assign rem_o  = rem_d;

endmodule

// ===== src/coalesced_hash_map.sv =====
// Channel | dir | tdata (low bit up)             | tuser (low bit up)
// s_axis  | in  | key, value_in, zero pad        | req_type
// m_axis  | out | value_out, entry_count, pad    | found, table_full
//
// A request computes the home slot remainder one nibble at a time, reads and checks
// each chain slot it walks, takes a decision step, and may then run the free slot
// scan or the removal scan; the single table RAM port sets the pace.
// After reset the table is cleared, one slot at a time, before the first request.
// Only one request is in flight; the result is held until it is taken.
module coalesced_hash_map
  import chm_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         s_axis_tvalid_i,
  output logic                                         s_axis_tready_o,
  // key, value_in
  input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata_i,
  // req_type
  input  logic [1:0]                                   s_axis_tuser_i,
  output logic                                         m_axis_tvalid_o,
  input  logic                                         m_axis_tready_i,
  // value_out, entry_count
  output logic [((VALUE_BITS+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata_o,
  // found, table_full
  output logic [1:0]                                   m_axis_tuser_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int OUT_DW = ((VALUE_BITS + LW + 7) / 8) * 8;
  localparam logic [LW-1:0] NO_LINK = LW'(CAPACITY);

  typedef struct packed {
    logic                  used;
    logic                  inch;
    logic [LW-1:0]         link;
    logic [IW-1:0]         home;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] val;
  } slot_t;

  state_e state_q, state_d;

  logic [1:0]            req_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [IW-1:0]         home_q, pos_q, tail_q, hit_idx_q, idx_q, free_idx_q, pred_idx_q;
  logic [LW-1:0]         steps_q, count_q;
  slot_t                 home_w_q, tail_w_q, hit_w_q, pred_w_q, rd;
  logic                  hit_q, home_used_q, is_home_q, pred_found_q;
  logic                  found_q, full_q;
  logic [VALUE_BITS-1:0] vout_q;

  logic                  we;
  logic [IW-1:0]         waddr, raddr;
  slot_t                 wdata;

  logic                  s_acc, mod_done;
  logic [KEY_BITS-1:0]   key_in, mag;
  logic [IW-1:0]         mod_rem;
  logic                  rd_match, rd_free;

  assign key_in = s_axis_tdata_i[KEY_BITS-1:0];
  assign mag    = key_in[KEY_BITS-1] ? (~key_in + 1'b1) : key_in;
  assign s_acc  = s_axis_tvalid_i && s_axis_tready_o;

  chm_mod #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_acc),
    .mag_i   (mag),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  chm_ram #(.WIDTH($bits(slot_t)), .DEPTH(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  assign rd_match = rd.used && (rd.key == key_q);
  assign rd_free  = !rd.used && !rd.inch && (rd.link == NO_LINK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = '0;
    raddr   = idx_q;
    case (state_q)
      ST_CLEAR: begin
        we         = 1'b1;
        wdata.link = NO_LINK;
        if (idx_q == IW'(CAPACITY - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_acc) begin
          state_d = ST_HOME;
        end
      end
      ST_HOME: begin
        if (mod_done) begin
          state_d = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        raddr   = pos_q;
        state_d = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (rd_match || rd.link == NO_LINK || steps_q == LW'(CAPACITY - 1)) begin
          state_d = ST_DECIDE;
        end else begin
          state_d = ST_WALK_RD;
        end
      end
      ST_DECIDE: begin
        state_d = ST_RESP;
        case (req_q)
          REQ_INSERT: begin
            if (hit_q) begin
              we        = 1'b1;
              waddr     = hit_idx_q;
              wdata     = hit_w_q;
              wdata.val = val_q;
            end else if (!home_used_q) begin
              we         = 1'b1;
              waddr      = home_q;
              wdata      = home_w_q;
              wdata.used = 1'b1;
              wdata.home = home_q;
              wdata.key  = key_q;
              wdata.val  = val_q;
            end else begin
              state_d = ST_FREE_RD;
            end
          end
          REQ_REMOVE: begin
            if (hit_q) begin
              we         = 1'b1;
              waddr      = hit_idx_q;
              wdata      = hit_w_q;
              wdata.used = 1'b0;
              wdata.key  = '0;
              wdata.val  = '0;
              if (hit_w_q.inch) begin
                state_d = ST_REM_RD;
              end
            end
          end
          default: begin
            state_d = ST_RESP;
          end
        endcase
      end
      ST_FREE_RD: begin
        state_d = ST_FREE_CHK;
      end
      ST_FREE_CHK: begin
        if (rd_free) begin
          we         = 1'b1;
          wdata.used = 1'b1;
          wdata.inch = 1'b1;
          wdata.link = NO_LINK;
          wdata.home = home_q;
          wdata.key  = key_q;
          wdata.val  = val_q;
          state_d    = ST_LINK_TAIL;
        end else if (idx_q == IW'(CAPACITY - 1)) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_FREE_RD;
        end
      end
      ST_LINK_TAIL: begin
        we         = 1'b1;
        waddr      = tail_q;
        wdata      = tail_w_q;
        wdata.link = LW'(free_idx_q);
        state_d    = ST_RESP;
      end
      ST_REM_RD: begin
        state_d = ST_REM_CHK;
      end
      ST_REM_CHK: begin
        if (idx_q == IW'(CAPACITY - 1)) begin
          state_d = ST_SPLICE;
        end else begin
          state_d = ST_REM_RD;
        end
      end
      ST_SPLICE: begin
        if (is_home_q) begin
          state_d = ST_RESP;
        end else begin
          if (pred_found_q) begin
            we         = 1'b1;
            waddr      = pred_idx_q;
            wdata      = pred_w_q;
            wdata.link = hit_w_q.link;
          end
          state_d = ST_UNLINK;
        end
      end
      ST_UNLINK: begin
        we         = 1'b1;
        waddr      = hit_idx_q;
        wdata      = hit_w_q;
        wdata.used = 1'b0;
        wdata.inch = 1'b0;
        wdata.link = NO_LINK;
        wdata.key  = '0;
        wdata.val  = '0;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        if (m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      count_q <= '0;
    end else begin
      case (state_q)
        ST_CLEAR, ST_FREE_CHK, ST_REM_CHK: begin
          if (!(state_q == ST_FREE_CHK && rd_free)) begin
            idx_q <= (idx_q == IW'(CAPACITY - 1)) ? '0 : idx_q + 1'b1;
          end
          if (state_q == ST_FREE_CHK && rd_free) begin
            count_q <= count_q + 1'b1;
          end
        end
        ST_DECIDE: begin
          idx_q <= '0;
          if (req_q == REQ_INSERT && !hit_q && !home_used_q) begin
            count_q <= count_q + 1'b1;
          end else if (req_q == REQ_REMOVE && hit_q) begin
            count_q <= count_q - 1'b1;
          end
        end
        default: begin
          idx_q <= idx_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        req_q <= s_axis_tuser_i;
        key_q <= key_in;
        val_q <= s_axis_tdata_i[KEY_BITS +: VALUE_BITS];
      end
      ST_HOME: begin
        home_q  <= mod_rem;
        pos_q   <= mod_rem;
        steps_q <= '0;
        hit_q   <= 1'b0;
      end
      ST_WALK_CHK: begin
        if (steps_q == '0) begin
          home_used_q <= rd.used;
          home_w_q    <= rd;
        end
        tail_q   <= pos_q;
        tail_w_q <= rd;
        if (rd_match) begin
          hit_q     <= 1'b1;
          hit_idx_q <= pos_q;
          hit_w_q   <= rd;
        end
        steps_q <= steps_q + 1'b1;
        pos_q   <= rd.link[IW-1:0];
      end
      ST_DECIDE: begin
        found_q      <= hit_q;
        vout_q       <= hit_q ? hit_w_q.val : '0;
        full_q       <= 1'b0;
        is_home_q    <= 1'b0;
        pred_found_q <= 1'b0;
      end
      ST_FREE_CHK: begin
        if (rd_free) begin
          free_idx_q <= idx_q;
        end else if (idx_q == IW'(CAPACITY - 1)) begin
          full_q <= 1'b1;
        end
      end
      ST_REM_CHK: begin
        if (rd.used && rd.home == hit_idx_q) begin
          is_home_q <= 1'b1;
        end
        if (!pred_found_q && rd.link == LW'(hit_idx_q)) begin
          pred_found_q <= 1'b1;
          pred_idx_q   <= idx_q;
          pred_w_q     <= rd;
        end
      end
      default: begin
        req_q <= req_q;
      end
    endcase
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_RESP);
  assign m_axis_tdata_o  = OUT_DW'({count_q, vout_q});
  assign m_axis_tuser_o  = {full_q, found_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= LW'(CAPACITY))
    else $error("Entry count exceeds the table capacity.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o && m_axis_tuser_o[1] |-> !m_axis_tuser_o[0] && m_axis_tdata_o[VALUE_BITS-1:0] == '0)
    else $error("A rejected insert reports a found key or a value.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      s_axis_tvalid_i && s_axis_tready_o |=> state_q == ST_HOME && !s_axis_tready_o)
    else $error("An accepted transaction did not start the remainder step.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o && m_axis_tuser_o[1] |-> req_q == REQ_INSERT)
    else $error("Table full was reported for a request other than insert.");

endmodule

// ===== bench/testbench.sv =====
// Testbench for coalesced_hash_map: drives insert, search, remove and other requests on the
// input stream and checks every result against a behavioral model of the table.
// Depends on chm_pkg and coalesced_hash_map.
`timescale 1ns / 100ps

class map_scoreboard;
  logic [31:0] key_q[16];
  logic [31:0] val_q[16];
  bit          used_q[16];
  int          link_q[16];
  bit          chained_q[16];
  int          count;
  logic [39:0] pending[$];
  int          errors;

  function new();
    for (int i = 0; i < 16; i++) begin
      key_q[i] = 0; val_q[i] = 0; used_q[i] = 0; link_q[i] = 16; chained_q[i] = 0;
    end
    count = 0;
    errors = 0;
  endfunction

  function int home_slot(logic [31:0] k);
    logic [31:0] mag;
    mag = k[31] ? (~k + 1) : k;
    return mag % 16;
  endfunction

  // Computes the result of one accepted request and updates the table copy.
  function void note_request(chm_pkg::req_e req, logic [31:0] k, logic [31:0] v);
    int h, pos, tail, hit, f;
    bit fnd, full, is_home;
    logic [31:0] vout;
    h = home_slot(k);
    pos = h; tail = h; hit = 16; fnd = 0; full = 0; vout = 0;
    for (int s = 0; s < 16 && pos < 16; s++) begin
      tail = pos;
      if (used_q[pos] && key_q[pos] == k) begin
        hit = pos;
        break;
      end
      pos = link_q[pos];
    end
    if (hit < 16) begin
      fnd = 1;
      vout = val_q[hit];
    end
    if (req == chm_pkg::REQ_INSERT) begin
      if (hit < 16) val_q[hit] = v;
      else if (!used_q[h]) begin
        used_q[h] = 1; key_q[h] = k; val_q[h] = v; count++;
      end else begin
        f = 16;
        for (int i = 0; i < 16; i++)
          if (!used_q[i] && !chained_q[i] && link_q[i] == 16) begin
            f = i;
            break;
          end
        if (f == 16) full = 1;
        else begin
          link_q[tail] = f; chained_q[f] = 1; used_q[f] = 1;
          key_q[f] = k; val_q[f] = v; count++;
        end
      end
    end else if (req == chm_pkg::REQ_REMOVE && hit < 16) begin
      used_q[hit] = 0; key_q[hit] = 0; val_q[hit] = 0; count--;
      if (chained_q[hit]) begin
        is_home = 0;
        for (int i = 0; i < 16; i++)
          if (used_q[i] && home_slot(key_q[i]) == hit) is_home = 1;
        if (!is_home) begin
          for (int i = 0; i < 16; i++)
            if (link_q[i] == hit) begin
              link_q[i] = link_q[hit];
              break;
            end
          link_q[hit] = 16;
          chained_q[hit] = 0;
        end
      end
    end
    pending.push_back({fnd, vout, full, count[4:0]} >> 0);
  endfunction

  function void check_result(logic [39:0] tdata, logic [1:0] tuser);
    logic [39:0] exp;
    logic [38:0] got, want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result tdata=%h tuser=%b", $time, tdata, tuser);
      errors++;
      return;
    end
    exp = pending.pop_front();
    want = exp[38:0];
    got = {tuser[0], tdata[31:0], tuser[1], tdata[36:32]};
    if (got[38] !== want[38])
      $display("%0t: found expected %b actual %b", $time, want[38], got[38]);
    if (got[37:6] !== want[37:6])
      $display("%0t: value_out expected %h actual %h", $time, want[37:6], got[37:6]);
    if (got[5] !== want[5])
      $display("%0t: table_full expected %b actual %b", $time, want[5], got[5]);
    if (got[4:0] !== want[4:0])
      $display("%0t: entry_count expected %0d actual %0d", $time, want[4:0], got[4:0]);
    if (got !== want || tdata[39:37] !== 0) errors++;
  endfunction
endclass

module testbench;
  import chm_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid_i = 0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 0;
  logic [39:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  map_scoreboard board = new();
  bit  sending_done = 0;
  bit  hold_off = 0;
  int  cycles = 0;
  logic [31:0] key_pool[8];

  coalesced_hash_map dut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_request(req_e req, logic [31:0] k, logic [31:0] v);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tuser_i <= req;
    s_axis_tdata_i <= {v, k};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.note_request(req, k, v);
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000 | ($urandom_range(0, 3) * 16);
      2: return -($urandom_range(0, 60));
      default: return key_pool[$urandom_range(0, 7)];
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i)
      board.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  initial begin : receiver
    int stall;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) m_axis_tready_i <= 0;
      else if (m_axis_tready_i && !m_axis_tvalid_o) begin
      end else begin
        stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
        if (stall > 0) begin
          m_axis_tready_i <= 0;
          repeat (stall - 1) @(posedge clk_i);
          @(posedge clk_i);
        end
        m_axis_tready_i <= 1;
      end
    end
  end

  initial begin : stimulus
    logic [31:0] k;
    int wait_cycles;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    foreach (key_pool[i]) key_pool[i] = $urandom_range(0, 3) * 16 + $urandom_range(0, 2);
    send_request(REQ_SEARCH, 32'h0, 32'h0);
    send_request(REQ_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'h7FFF_FFFF, 32'h0);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h1234_5678);
    send_request(REQ_INSERT, 32'h0, 32'hA5A5_A5A5);
    send_request(REQ_INSERT, 32'h0, 32'h5A5A_5A5A);
    send_request(REQ_OTHER, 32'h0, 32'h0);
    for (int i = 0; i < 13; i++) send_request(REQ_INSERT, i * 16 + 16, i);
    send_request(REQ_INSERT, 32'd999, 32'd7);
    send_request(REQ_REMOVE, 32'd48, 32'h0);
    send_request(REQ_REMOVE, 32'd1, 32'h0);
    send_request(REQ_REMOVE, 32'h7FFF_FFFF, 32'h0);
    send_request(REQ_INSERT, 32'd15, 32'd3);
    send_request(REQ_SEARCH, 32'd64, 32'h0);
    for (int i = 0; i < 1950; i++) begin
      if (i == 900) fork
        begin
          hold_off = 1;
          repeat (400) @(posedge clk_i);
          hold_off = 0;
        end
      join_none
      if (i % 300 == 299)
        foreach (key_pool[j]) key_pool[j] = $urandom_range(0, 7) * 16 + $urandom_range(0, 3);
      k = pick_key();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_request(REQ_INSERT, k, $urandom());
        4, 5: send_request(REQ_SEARCH, k, $urandom());
        9: send_request(REQ_OTHER, k, $urandom());
        default: send_request(REQ_REMOVE, k, $urandom());
      endcase
    end
    s_axis_tvalid_i <= 0;
    wait_cycles = 0;
    while (board.pending.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
